>>> rtl/sorted_expiry_timer_queue_unit_macros.svh
// Assertion helpers for the queue checker.
`ifndef SORTED_EXPIRY_TIMER_QUEUE_UNIT_MACROS_SVH
`define SORTED_EXPIRY_TIMER_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define SETQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer queue check failed");

// Next-cycle implication, skipped while reset is high.
`define SETQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer queue check failed");

`endif

>>> rtl/setq_pkg.sv
package setq_pkg;

   // Fixed field widths of the stream beats
   localparam int SLOT_BITS       = 6;
   localparam int FIELD_TIME_BITS = 32;

   // Request tdata layout: slot, expiry, now, zero pad to 72 bits
   localparam int REQ_SLOT_LSB    = 0;
   localparam int REQ_EXPIRY_LSB  = REQ_SLOT_LSB + SLOT_BITS;
   localparam int REQ_NOW_LSB     = REQ_EXPIRY_LSB + FIELD_TIME_BITS;
   localparam int REQ_USED_BITS   = REQ_NOW_LSB + FIELD_TIME_BITS;
   localparam int REQ_TDATA_BITS  = ((REQ_USED_BITS + 7) / 8) * 8;

   // Response tdata layout: fired_slot, status
   localparam int STATUS_BITS     = 2;
   localparam int RSP_SLOT_LSB    = 0;
   localparam int RSP_STATUS_LSB  = RSP_SLOT_LSB + SLOT_BITS;
   localparam int RSP_TDATA_BITS  = RSP_STATUS_LSB + STATUS_BITS;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ADJUST = 2'd1,
      OP_DELETE = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_QUEUED  = 2'd1,
      STATUS_MISSING = 2'd2
   } status_type;

   // Action broadcast to every cell of the chain
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [SLOT_BITS-1:0] slot;
   } cell_cmd_type;

endpackage

>>> rtl/setq_cell.sv
module setq_cell #(
   parameter int TIME_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  setq_pkg::cell_cmd_type         cmd,
   input  logic                           take_next,
   input  logic [TIME_BITS-1:0]           new_expiry,
   input  logic                           prev_keep,
   input  logic                           prev_valid,
   input  logic [setq_pkg::SLOT_BITS-1:0] prev_slot,
   input  logic [TIME_BITS-1:0]           prev_expiry,
   input  logic                           next_valid,
   input  logic [setq_pkg::SLOT_BITS-1:0] next_slot,
   input  logic [TIME_BITS-1:0]           next_expiry,
   output logic                           valid,
   output logic [setq_pkg::SLOT_BITS-1:0] slot,
   output logic [TIME_BITS-1:0]           expiry,
   output logic                           keep,
   output logic                           match
);

   logic                           valid_ff, valid_in;
   logic [setq_pkg::SLOT_BITS-1:0] slot_ff, slot_in;
   logic [TIME_BITS-1:0]           expiry_ff, expiry_in;

   // Local compares: entry sorts at or before the new time, entry owns the slot
   assign keep  = valid_ff && (expiry_ff <= new_expiry);
   assign match = valid_ff && (slot_ff == cmd.slot);

   // Pick the next content: hold, take the new entry, or take a neighbor
   always_comb begin
      valid_in  = valid_ff;
      slot_in   = slot_ff;
      expiry_in = expiry_ff;
      unique case (cmd.op)
         setq_pkg::CELL_INSERT: begin
            if (!keep) begin
               if (prev_keep) begin
                  valid_in  = 1'b1;
                  slot_in   = cmd.slot;
                  expiry_in = new_expiry;
               end else begin
                  valid_in  = prev_valid;
                  slot_in   = prev_slot;
                  expiry_in = prev_expiry;
               end
            end
         end
         setq_pkg::CELL_REMOVE: begin
            if (take_next) begin
               valid_in  = next_valid;
               slot_in   = next_slot;
               expiry_in = next_expiry;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      slot_ff   <= slot_in;
      expiry_ff <= expiry_in;
   end

   assign valid  = valid_ff;
   assign slot   = slot_ff;
   assign expiry = expiry_ff;

endmodule

>>> rtl/sorted_expiry_timer_queue_unit.sv
// Sorted timer queue: a chain of MAX_TIMERS cells holds the queued timers in
// ascending expiry order (equal expiries keep arrival order); at most 64
// distinct slots can be queued. Every request beat is latched and then
// applied to the whole chain by one sequencer step per cycle while the
// output register is free, each cell comparing locally and taking its
// own, its left or its right neighbor's entry. Insert and delete apply in
// the EXEC step, adjust removes in EXEC and re-inserts in REINSERT, and a
// tick pops the due timers in POP, one pop per cycle. The result beat of
// insert and delete, and the first result beat of a tick, is registered by
// the step after the request is latched; the result beat of adjust by the
// re-insert step. Every step waits while an earlier result beat is stalled
// in the output register. A new request beat is taken once the previous one
// has finished, even while its last result beat still waits in the output
// register. Times are taken in their low TIME_BITS bits.
module sorted_expiry_timer_queue_unit #(
   parameter int MAX_TIMERS = 64,
   parameter int TIME_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: slot [5:0], expiry [37:6], now [69:38], zero [71:70]
   input  logic [setq_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // tuser: operation [1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: fired_slot [5:0], status [7:6]
   output logic [setq_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // tuser: fired [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REINSERT,
      ST_POP
   } state_type;

   state_type                      state_ff, state_in;
   setq_pkg::op_type               op_ff, op_in;
   logic [setq_pkg::SLOT_BITS-1:0] slot_ff, slot_in;
   logic [TIME_BITS-1:0]           expiry_ff, expiry_in;
   logic [TIME_BITS-1:0]           now_ff, now_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [setq_pkg::SLOT_BITS-1:0] rsp_slot_ff, rsp_slot_in;
   setq_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic                           rsp_fired_ff, rsp_fired_in;
   logic                           rsp_last_ff, rsp_last_in;

   setq_pkg::cell_cmd_type         cmd;
   logic [TIME_BITS-1:0]           cmp_time;
   logic                           out_free;
   logic                           found;
   logic                           full;

   logic [MAX_TIMERS-1:0]          cell_valid;
   logic [MAX_TIMERS-1:0]          cell_keep;
   logic [MAX_TIMERS-1:0]          cell_match;
   logic [MAX_TIMERS-1:0]          take_next;
   logic [setq_pkg::SLOT_BITS-1:0] cell_slot [MAX_TIMERS];
   logic [TIME_BITS-1:0]           cell_expiry [MAX_TIMERS];

   // Compare against now while popping, against the request expiry otherwise
   assign cmp_time = (state_ff == ST_POP) ? now_ff : expiry_ff;
   assign found    = |cell_match;
   assign full     = cell_valid[MAX_TIMERS-1];
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Build the chain
   for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
      logic                           prev_keep;
      logic                           prev_valid;
      logic [setq_pkg::SLOT_BITS-1:0] prev_slot;
      logic [TIME_BITS-1:0]           prev_expiry;
      logic                           next_valid;
      logic [setq_pkg::SLOT_BITS-1:0] next_slot;
      logic [TIME_BITS-1:0]           next_expiry;

      if (i == 0) begin : g_head
         assign prev_keep   = 1'b1;
         assign prev_valid  = 1'b0;
         assign prev_slot   = '0;
         assign prev_expiry = '0;
      end else begin : g_body
         assign prev_keep   = cell_keep[i-1];
         assign prev_valid  = cell_valid[i-1];
         assign prev_slot   = cell_slot[i-1];
         assign prev_expiry = cell_expiry[i-1];
      end

      if (i == MAX_TIMERS - 1) begin : g_tail
         assign next_valid  = 1'b0;
         assign next_slot   = '0;
         assign next_expiry = '0;
      end else begin : g_link
         assign next_valid  = cell_valid[i+1];
         assign next_slot   = cell_slot[i+1];
         assign next_expiry = cell_expiry[i+1];
      end

      // Close the gap from the matching cell onward, or shift all on a pop
      assign take_next[i] = (state_ff == ST_POP) || (|cell_match[i:0]);

      setq_cell #(
         .TIME_BITS(TIME_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .take_next  (take_next[i]),
         .new_expiry (cmp_time),
         .prev_keep  (prev_keep),
         .prev_valid (prev_valid),
         .prev_slot  (prev_slot),
         .prev_expiry(prev_expiry),
         .next_valid (next_valid),
         .next_slot  (next_slot),
         .next_expiry(next_expiry),
         .valid      (cell_valid[i]),
         .slot       (cell_slot[i]),
         .expiry     (cell_expiry[i]),
         .keep       (cell_keep[i]),
         .match      (cell_match[i])
      );
   end

   // Sequencer: latch the request, step the chain, load the result register
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      slot_in       = slot_ff;
      expiry_in     = expiry_ff;
      now_in        = now_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_last_in   = rsp_last_ff;
      cmd.op        = setq_pkg::CELL_HOLD;
      cmd.slot      = slot_ff;
      req_tready    = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = setq_pkg::op_type'(req_tuser);
               slot_in   = req_tdata[setq_pkg::REQ_SLOT_LSB +: setq_pkg::SLOT_BITS];
               expiry_in = TIME_BITS'(req_tdata[setq_pkg::REQ_EXPIRY_LSB +:
                                                setq_pkg::FIELD_TIME_BITS]);
               now_in    = TIME_BITS'(req_tdata[setq_pkg::REQ_NOW_LSB +:
                                                setq_pkg::FIELD_TIME_BITS]);
               state_in  = (setq_pkg::op_type'(req_tuser) == setq_pkg::OP_TICK) ?
                           ST_POP : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_slot_in   = slot_ff;
               rsp_fired_in  = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = setq_pkg::STATUS_OK;
               state_in      = ST_IDLE;
               if (op_ff == setq_pkg::OP_INSERT) begin
                  if (found || full) begin
                     rsp_status_in = setq_pkg::STATUS_QUEUED;
                  end else begin
                     cmd.op = setq_pkg::CELL_INSERT;
                  end
               end else if (!found) begin
                  rsp_status_in = setq_pkg::STATUS_MISSING;
               end else begin
                  cmd.op = setq_pkg::CELL_REMOVE;
                  if (op_ff == setq_pkg::OP_ADJUST) begin
                     // Result follows the re-insert
                     rsp_valid_in = 1'b0;
                     state_in     = ST_REINSERT;
                  end
               end
            end
         end
         ST_REINSERT: begin
            if (out_free) begin
               cmd.op        = setq_pkg::CELL_INSERT;
               rsp_slot_in   = slot_ff;
               rsp_fired_in  = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_status_in = setq_pkg::STATUS_OK;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_POP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = setq_pkg::STATUS_OK;
               state_in      = ST_IDLE;
               if (cell_keep[0]) begin
                  // Pop the head; the next cell tells whether more are due
                  cmd.op       = setq_pkg::CELL_REMOVE;
                  rsp_slot_in  = cell_slot[0];
                  rsp_fired_in = 1'b1;
                  rsp_last_in  = !cell_keep[1];
                  if (cell_keep[1]) begin
                     state_in = ST_POP;
                  end
               end else begin
                  rsp_slot_in  = '0;
                  rsp_fired_in = 1'b0;
                  rsp_last_in  = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      expiry_ff     <= expiry_in;
      now_ff        <= now_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_status_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_fired_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/setq_chk.sv
`include "sorted_expiry_timer_queue_unit_macros.svh"

module setq_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [setq_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input logic                                rsp_tuser,
   input logic                                rsp_tlast
);

   logic [setq_pkg::STATUS_BITS-1:0] status;

   assign status = rsp_tdata[setq_pkg::RSP_STATUS_LSB +: setq_pkg::STATUS_BITS];

   // Status results and empty ticks stand alone
   `SETQ_ASSERT_IMPLY(a_unfired_last, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast)

   // A popped timer always reports ok
   `SETQ_ASSERT_IMPLY(a_fired_ok, clock, reset, rsp_tvalid && rsp_tuser, status == setq_pkg::STATUS_OK)

   // Only defined status codes leave the block
   `SETQ_ASSERT_IMPLY(a_status_code, clock, reset, rsp_tvalid, status == setq_pkg::STATUS_OK || status == setq_pkg::STATUS_QUEUED || status == setq_pkg::STATUS_MISSING)

   // A stalled result beat holds
   `SETQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule

bind sorted_expiry_timer_queue_unit setq_chk u_setq_chk (.*);

>>> tb/sv/tb_sorted_expiry_timer_queue_unit.sv
module tb_sorted_expiry_timer_queue_unit;

   localparam int TIMER_CAPACITY = 64;
   localparam int TIMER_TIME_BITS = 32;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [setq_pkg::FIELD_TIME_BITS-1:0] expiry;
      logic [setq_pkg::SLOT_BITS-1:0]       slot;
   } timer_entry;

   typedef struct packed {
      logic [setq_pkg::SLOT_BITS-1:0] slot;
      logic                           fired;
      setq_pkg::status_type           status;
      logic                           last;
   } timer_result;

   // One request beat; typed rows carry their single result
   typedef struct packed {
      setq_pkg::op_type                     op;
      logic [setq_pkg::SLOT_BITS-1:0]       slot;
      logic [setq_pkg::FIELD_TIME_BITS-1:0] expiry;
      logic [setq_pkg::FIELD_TIME_BITS-1:0] now;
      logic                                 typed;
      timer_result                          want;
   } stim_row;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [setq_pkg::REQ_TDATA_BITS-1:0] req_tdata;
   logic [1:0]                          req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [setq_pkg::RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                                rsp_tuser;
   logic                                rsp_tlast;

   timer_entry  timer_list[$];
   timer_result step_results[$];
   timer_result pending_results[$];
   stim_row     directed_rows[22];

   int          error_count = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_cycles = 0;
   logic [31:0] time_base;
   logic        req_typed = 1'b0;
   timer_result req_want = '0;

   sorted_expiry_timer_queue_unit #(
      .MAX_TIMERS(TIMER_CAPACITY),
      .TIME_BITS (TIMER_TIME_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Position of a slot in the sorted list, -1 when not queued
   function automatic int find_timer(input logic [setq_pkg::SLOT_BITS-1:0] slot);
      for (int i = 0; i < timer_list.size(); i++) begin
         if (timer_list[i].slot == slot) return i;
      end
      return -1;
   endfunction

   // Place after every entry with an equal or earlier expiry
   task automatic place_timer(input logic [setq_pkg::SLOT_BITS-1:0] slot,
                              input logic [setq_pkg::FIELD_TIME_BITS-1:0] expiry);
      int pos;
      timer_entry e;
      pos = 0;
      while (pos < timer_list.size() && timer_list[pos].expiry <= expiry) pos++;
      e.expiry = expiry;
      e.slot = slot;
      timer_list.insert(pos, e);
   endtask

   // Advance the timer list by one request and collect its results
   task automatic apply_timer_op(input setq_pkg::op_type op,
                                 input logic [setq_pkg::SLOT_BITS-1:0] slot,
                                 input logic [setq_pkg::FIELD_TIME_BITS-1:0] expiry,
                                 input logic [setq_pkg::FIELD_TIME_BITS-1:0] now);
      int pos;
      timer_result r;
      step_results.delete();
      if (op == setq_pkg::OP_TICK) begin
         // pop every timer that is due, earliest first
         while (timer_list.size() > 0 && timer_list[0].expiry <= now) begin
            r = '{timer_list[0].slot, 1'b1, setq_pkg::STATUS_OK, 1'b0};
            step_results.push_back(r);
            void'(timer_list.pop_front());
         end
         if (step_results.size() == 0) begin
            step_results.push_back('{'0, 1'b0, setq_pkg::STATUS_OK, 1'b1});
         end else begin
            r = step_results.pop_back();
            r.last = 1'b1;
            step_results.push_back(r);
         end
         return;
      end
      pos = find_timer(slot);
      r = '{slot, 1'b0, setq_pkg::STATUS_OK, 1'b1};
      if (op == setq_pkg::OP_INSERT) begin
         if (pos >= 0 || timer_list.size() >= TIMER_CAPACITY) begin
            r.status = setq_pkg::STATUS_QUEUED;
         end else begin
            place_timer(slot, expiry);
         end
      end else if (pos < 0) begin
         r.status = setq_pkg::STATUS_MISSING;
      end else begin
         timer_list.delete(pos);
         if (op == setq_pkg::OP_ADJUST) place_timer(slot, expiry);
      end
      step_results.push_back(r);
   endtask

   // Predict on each request beat, check each result beat
   always @(posedge clock) begin : result_monitor
      timer_result got;
      timer_result want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_timer_op(setq_pkg::op_type'(req_tuser),
                           req_tdata[setq_pkg::REQ_SLOT_LSB +: setq_pkg::SLOT_BITS],
                           req_tdata[setq_pkg::REQ_EXPIRY_LSB +: setq_pkg::FIELD_TIME_BITS],
                           req_tdata[setq_pkg::REQ_NOW_LSB +: setq_pkg::FIELD_TIME_BITS]);
            if (req_typed) pending_results.push_back(req_want);
            else foreach (step_results[i]) pending_results.push_back(step_results[i]);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.slot = rsp_tdata[setq_pkg::RSP_SLOT_LSB +: setq_pkg::SLOT_BITS];
            got.fired = rsp_tuser;
            got.status = setq_pkg::status_type'(
               rsp_tdata[setq_pkg::RSP_STATUS_LSB +: setq_pkg::STATUS_BITS]);
            got.last = rsp_tlast;
            if (pending_results.size() == 0) begin
               $display("%0t: result beat with nothing pending: %s",
                        $time, $sformatf("slot %0d fired %0b status %0d last %0b",
                                         got.slot, got.fired, got.status, got.last));
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.slot !== want.slot || got.fired !== want.fired ||
                   got.status !== want.status || got.last !== want.last) begin
                  $display("%0t: mismatch: expected %s, got %s", $time,
                           $sformatf("slot %0d fired %0b status %0d last %0b",
                                     want.slot, want.fired, want.status, want.last),
                           $sformatf("slot %0d fired %0b status %0d last %0b",
                                     got.slot, got.fired, got.status, got.last));
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver: random stalls, or a long counted hold-off when requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Offer one beat and hold it until the block takes it
   task automatic send_item(input stim_row r);
      logic [setq_pkg::REQ_TDATA_BITS-1:0] data;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      data = '0;
      data[setq_pkg::REQ_SLOT_LSB +: setq_pkg::SLOT_BITS] = r.slot;
      data[setq_pkg::REQ_EXPIRY_LSB +: setq_pkg::FIELD_TIME_BITS] = r.expiry;
      data[setq_pkg::REQ_NOW_LSB +: setq_pkg::FIELD_TIME_BITS] = r.now;
      req_tvalid <= 1'b1;
      req_tuser <= r.op;
      req_tdata <= data;
      req_typed = r.typed;
      req_want = r.want;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Mostly a slot that is (or is not) queued, so requests hit live timers
   function automatic logic [setq_pkg::SLOT_BITS-1:0] pick_slot(input bit queued);
      logic [setq_pkg::SLOT_BITS-1:0] s;
      s = setq_pkg::SLOT_BITS'($urandom);
      if (queued && timer_list.size() > 0) begin
         s = timer_list[$urandom_range(0, timer_list.size() - 1)].slot;
      end else if (!queued) begin
         for (int tries = 0; tries < 8 && find_timer(s) >= 0; tries++) begin
            s = setq_pkg::SLOT_BITS'($urandom);
         end
      end
      return s;
   endfunction

   // Expiries cluster just ahead of the running time so ties and pops are common
   function automatic stim_row make_random_row();
      stim_row r;
      int pick;
      r = '0;
      pick = $urandom_range(0, 99);
      r.expiry = ($urandom_range(0, 99) < 8) ? $urandom : time_base + $urandom_range(0, 40);
      r.now = $urandom;
      if (pick < 40) begin
         r.op = setq_pkg::OP_INSERT;
         r.slot = pick_slot($urandom_range(0, 99) < 20);
      end else if (pick < 55) begin
         r.op = setq_pkg::OP_ADJUST;
         r.slot = pick_slot($urandom_range(0, 99) < 85);
      end else if (pick < 70) begin
         r.op = setq_pkg::OP_DELETE;
         r.slot = pick_slot($urandom_range(0, 99) < 85);
      end else begin
         r.op = setq_pkg::OP_TICK;
         r.slot = setq_pkg::SLOT_BITS'($urandom);
         if ($urandom_range(0, 99) >= 6) begin
            r.now = time_base + $urandom_range(0, 25);
            time_base = r.now;
         end
      end
      return r;
   endfunction

   task automatic send_random_items(input int count);
      for (int i = 0; i < count; i++) send_item(make_random_row());
   endtask

   initial begin
      #400000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [setq_pkg::SLOT_BITS-1:0] order[TIMER_CAPACITY];
      logic [setq_pkg::SLOT_BITS-1:0] swap;
      int j;
      stim_row r;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      time_base = $urandom;
      directed_rows = '{
         // tick on an empty list
         '{setq_pkg::OP_TICK,   6'd0,  32'd0,        32'd0,        1'b1,
           '{6'd0, 1'b0, setq_pkg::STATUS_OK, 1'b1}},
         // delete and adjust of slots never queued
         '{setq_pkg::OP_DELETE, 6'd63, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1,
           '{6'd63, 1'b0, setq_pkg::STATUS_MISSING, 1'b1}},
         '{setq_pkg::OP_ADJUST, 6'd0,  32'd0,        32'd0,        1'b1,
           '{6'd0, 1'b0, setq_pkg::STATUS_MISSING, 1'b1}},
         // extreme expiries, then a duplicate insert
         '{setq_pkg::OP_INSERT, 6'd0,  32'd0,        32'hFFFFFFFF, 1'b1,
           '{6'd0, 1'b0, setq_pkg::STATUS_OK, 1'b1}},
         '{setq_pkg::OP_INSERT, 6'd63, 32'hFFFFFFFF, 32'd0,        1'b1,
           '{6'd63, 1'b0, setq_pkg::STATUS_OK, 1'b1}},
         '{setq_pkg::OP_INSERT, 6'd0,  32'd5,        32'd0,        1'b1,
           '{6'd0, 1'b0, setq_pkg::STATUS_QUEUED, 1'b1}},
         // equal expiries keep arrival order; adjust earlier and later
         '{setq_pkg::OP_INSERT, 6'd5,  32'd100,      32'd0,        1'b0, '0},
         '{setq_pkg::OP_INSERT, 6'd6,  32'd100,      32'd0,        1'b0, '0},
         '{setq_pkg::OP_INSERT, 6'd7,  32'd50,       32'd0,        1'b0, '0},
         '{setq_pkg::OP_ADJUST, 6'd5,  32'd10,       32'd0,        1'b0, '0},
         '{setq_pkg::OP_ADJUST, 6'd7,  32'd200,      32'd0,        1'b0, '0},
         '{setq_pkg::OP_TICK,   6'd0,  32'd0,        32'd100,      1'b0, '0},
         '{setq_pkg::OP_DELETE, 6'd7,  32'd0,        32'd0,        1'b1,
           '{6'd7, 1'b0, setq_pkg::STATUS_OK, 1'b1}},
         '{setq_pkg::OP_DELETE, 6'd7,  32'd0,        32'd0,        1'b1,
           '{6'd7, 1'b0, setq_pkg::STATUS_MISSING, 1'b1}},
         // one short of the latest expiry, then the latest time
         '{setq_pkg::OP_TICK,   6'd0,  32'd0,        32'hFFFFFFFE, 1'b1,
           '{6'd0, 1'b0, setq_pkg::STATUS_OK, 1'b1}},
         '{setq_pkg::OP_TICK,   6'd0,  32'd0,        32'hFFFFFFFF, 1'b1,
           '{6'd63, 1'b1, setq_pkg::STATUS_OK, 1'b1}},
         // alternating bit patterns; now ignored by insert
         '{setq_pkg::OP_INSERT, 6'd42, 32'hAAAAAAAA, 32'h55555555, 1'b0, '0},
         '{setq_pkg::OP_INSERT, 6'd21, 32'h55555555, 32'hAAAAAAAA, 1'b0, '0},
         '{setq_pkg::OP_TICK,   6'd0,  32'd0,        32'd0,        1'b1,
           '{6'd0, 1'b0, setq_pkg::STATUS_OK, 1'b1}},
         // delete ignores expiry; tick ignores slot
         '{setq_pkg::OP_DELETE, 6'd42, 32'hFFFFFFFF, 32'd0,        1'b1,
           '{6'd42, 1'b0, setq_pkg::STATUS_OK, 1'b1}},
         '{setq_pkg::OP_ADJUST, 6'd21, 32'd0,        32'd0,        1'b0, '0},
         '{setq_pkg::OP_TICK,   6'd63, 32'hFFFFFFFF, 32'd0,        1'b1,
           '{6'd21, 1'b1, setq_pkg::STATUS_OK, 1'b1}}
      };

      // sender idles often, receiver stalls more
      send_idle_pct = 31;
      recv_idle_pct = 67;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[k]) send_item(directed_rows[k]);
      send_random_items(70);

      // swap the idle ratios
      send_idle_pct = 67;
      recv_idle_pct = 31;
      send_random_items(70);

      // no idling; queue every slot while the receiver starts out held off
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = LONG_HOLD_CYCLES;
      for (int k = 0; k < TIMER_CAPACITY; k++) order[k] = setq_pkg::SLOT_BITS'(k);
      for (int k = TIMER_CAPACITY - 1; k > 0; k--) begin
         j = int'($urandom_range(0, k));
         swap = order[k];
         order[k] = order[j];
         order[j] = swap;
      end
      for (int k = 0; k < TIMER_CAPACITY; k++) begin
         r = '0;
         r.op = setq_pkg::OP_INSERT;
         r.slot = order[k];
         r.expiry = time_base + $urandom_range(0, 15);
         r.now = $urandom;
         send_item(r);
      end
      // pop the full list in one tick
      r = '0;
      r.op = setq_pkg::OP_TICK;
      r.now = 32'hFFFFFFFF;
      send_item(r);
      send_random_items(45);

      // drain, then let trailing beats show up
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/setq_pkg.sv
rtl/setq_cell.sv
rtl/sorted_expiry_timer_queue_unit.sv
rtl/setq_chk.sv
tb/sv/tb_sorted_expiry_timer_queue_unit.sv
